[hdl/lgtr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LDA token resampler package
// Shared constants, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package lgtr_pkg;

  localparam int DEF_MAX_TOPICS = 64;
  localparam int DEF_MAX_DOCS   = 1024;
  localparam int DEF_MAX_WORDS  = 4096;

  localparam int DOC_W    = 10;
  localparam int WORD_W   = 12;
  localparam int PRIOR_W  = 6;
  localparam int RAND_W   = 32;
  localparam int TOPIC_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_TOPICS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOCAB  = 2'd3;

  localparam logic [6:0]  RST_TOPICS = 7'd50;
  localparam logic [23:0] RST_ALPHA  = 24'd1311;
  localparam logic [23:0] RST_BETA   = 24'd6554;
  localparam logic [20:0] RST_VOCAB  = 21'd4096;

  // Number of compare/subtract steps that fold an index into its table.
  localparam int RED_STEPS = 12;
  // Quotient bits produced by the serial divider.
  localparam int QUO_W = 48;

  typedef enum logic [1:0] {
    AS_PRIOR,
    AS_TOPIC,
    AS_CLEAR
  } addr_sel_e;

  typedef enum logic [1:0] {
    WOP_DEC,
    WOP_INC,
    WOP_CLR
  } wr_op_e;

  typedef struct packed {
    logic      latch;
    logic      red_en;
    logic [3:0] red_k;
    logic      base_ld;
    logic      t_clr;
    logic      t_inc;
    logic      mem_rd;
    logic      mem_wr;
    addr_sel_e asel;
    wr_op_e    wop;
    logic      ab_ld;
    logic      mul_ld;
    logic      div_init;
    logic      div_step;
    logic      acc;
    logic      thr_hi;
    logic      thr_lo;
    logic      thr_sum;
    logic      wb_rd;
    logic      srch;
    logic      out_ld;
  } cmd_t;

  typedef struct packed {
    logic need_rm;
    logic t_last;
    logic hit;
    logic clr_last;
  } sts_t;

endpackage
`default_nettype wire

[hdl/lgtr_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LDA token resampler channels
// Token input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lgtr_tok_if;
  logic        valid;
  logic        ready;
  logic [9:0]  doc_index;
  logic [11:0] word_index;
  logic        has_prior_topic;
  logic [5:0]  prior_topic;
  logic [31:0] random_fraction;

  modport source (output valid, doc_index, word_index, has_prior_topic, prior_topic,
                  random_fraction, input ready);
  modport sink (input valid, doc_index, word_index, has_prior_topic, prior_topic,
                random_fraction, output ready);
endinterface

interface lgtr_res_if;
  logic       valid;
  logic       ready;
  logic [5:0] chosen_topic;
  logic       topic_changed;
  logic       count_underflow;

  modport source (output valid, chosen_topic, topic_changed, count_underflow, input ready);
  modport sink (input valid, chosen_topic, topic_changed, count_underflow, output ready);
endinterface
`default_nettype wire

[hdl/lgtr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LDA token resampler controller
// Sequences clearing, count removal, weight pass, draw and count update.
// ----------------------------------------------------------------------------
module lgtr_ctrl
  import lgtr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_REDUCE, S_BASE, S_RM_RD, S_RM_WR,
    S_W_RD, S_W_AB, S_W_MUL, S_W_DINIT, S_W_DIV, S_W_ACC,
    S_THR_HI, S_THR_LO, S_THR_SUM, S_S_RD, S_S_CMP,
    S_UP_RD, S_UP_WR, S_DONE
  } state_e;

  state_e     state_q;
  logic [5:0] step_q;
  logic       out_valid_q;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.asel = AS_TOPIC;
    cmd_o.wop  = WOP_INC;
    cmd_o.red_k = step_q[3:0];
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.mem_wr = 1'b1;
        cmd_o.asel   = AS_CLEAR;
        cmd_o.wop    = WOP_CLR;
      end
      S_IDLE:    cmd_o.latch = in_valid_i;
      S_REDUCE:  cmd_o.red_en = 1'b1;
      S_BASE: begin
        cmd_o.base_ld = 1'b1;
        cmd_o.t_clr   = 1'b1;
      end
      S_RM_RD: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.asel   = AS_PRIOR;
      end
      S_RM_WR: begin
        cmd_o.mem_wr = 1'b1;
        cmd_o.asel   = AS_PRIOR;
        cmd_o.wop    = WOP_DEC;
      end
      S_W_RD:    cmd_o.mem_rd = 1'b1;
      S_W_AB:    cmd_o.ab_ld = 1'b1;
      S_W_MUL:   cmd_o.mul_ld = 1'b1;
      S_W_DINIT: cmd_o.div_init = 1'b1;
      S_W_DIV:   cmd_o.div_step = 1'b1;
      S_W_ACC: begin
        cmd_o.acc   = 1'b1;
        cmd_o.t_inc = !sts_i.t_last;
      end
      S_THR_HI:  cmd_o.thr_hi = 1'b1;
      S_THR_LO:  cmd_o.thr_lo = 1'b1;
      S_THR_SUM: begin
        cmd_o.thr_sum = 1'b1;
        cmd_o.t_clr   = 1'b1;
      end
      S_S_RD:    cmd_o.wb_rd = 1'b1;
      S_S_CMP: begin
        cmd_o.srch  = 1'b1;
        cmd_o.t_inc = !(sts_i.hit || sts_i.t_last);
      end
      S_UP_RD:   cmd_o.mem_rd = 1'b1;
      S_UP_WR:   cmd_o.mem_wr = 1'b1;
      S_DONE:    cmd_o.out_ld = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR:  if (sts_i.clr_last) state_q <= S_IDLE;
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_REDUCE;
            step_q  <= 6'(RED_STEPS - 1);
          end
        end
        S_REDUCE: begin
          if (step_q == '0) state_q <= S_BASE;
          else step_q <= step_q - 6'd1;
        end
        S_BASE:    state_q <= sts_i.need_rm ? S_RM_RD : S_W_RD;
        S_RM_RD:   state_q <= S_RM_WR;
        S_RM_WR:   state_q <= S_W_RD;
        S_W_RD:    state_q <= S_W_AB;
        S_W_AB:    state_q <= S_W_MUL;
        S_W_MUL:   state_q <= S_W_DINIT;
        S_W_DINIT: begin
          state_q <= S_W_DIV;
          step_q  <= 6'(QUO_W - 1);
        end
        S_W_DIV: begin
          if (step_q == '0) state_q <= S_W_ACC;
          else step_q <= step_q - 6'd1;
        end
        S_W_ACC:   state_q <= sts_i.t_last ? S_THR_HI : S_W_RD;
        S_THR_HI:  state_q <= S_THR_LO;
        S_THR_LO:  state_q <= S_THR_SUM;
        S_THR_SUM: state_q <= S_S_RD;
        S_S_RD:    state_q <= S_S_CMP;
        S_S_CMP:   state_q <= (sts_i.hit || sts_i.t_last) ? S_UP_RD : S_S_RD;
        S_UP_RD:   state_q <= S_UP_WR;
        S_UP_WR:   state_q <= S_DONE;
        S_DONE: begin
          if (out_free) state_q <= S_IDLE;
        end
        default:   state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/lgtr_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LDA token resampler datapath
// Count memories, configuration, weight arithmetic, serial divider and draw.
// ----------------------------------------------------------------------------
module lgtr_dp
  import lgtr_pkg::*;
#(
  parameter int MAX_TOPICS = DEF_MAX_TOPICS,
  parameter int MAX_DOCS   = DEF_MAX_DOCS,
  parameter int MAX_WORDS  = DEF_MAX_WORDS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic [DOC_W-1:0]      doc_index_i,
  input  wire logic [WORD_W-1:0]     word_index_i,
  input  wire logic                  has_prior_topic_i,
  input  wire logic [PRIOR_W-1:0]    prior_topic_i,
  input  wire logic [RAND_W-1:0]     random_fraction_i,
  input  wire cmd_t                  cmd_i,
  output sts_t                       sts_o,
  output logic [TOPIC_W-1:0]         chosen_topic_o,
  output logic                       topic_changed_o,
  output logic                       count_underflow_o
);

  localparam int TIW      = $clog2(MAX_TOPICS);
  localparam int DT_DEPTH = MAX_DOCS * MAX_TOPICS;
  localparam int WT_DEPTH = MAX_WORDS * MAX_TOPICS;
  localparam int DTAW     = $clog2(DT_DEPTH);
  localparam int WTAW     = $clog2(WT_DEPTH);
  localparam int CLR_DEPTH = (DT_DEPTH > WT_DEPTH) ? DT_DEPTH : WT_DEPTH;
  localparam int CLW      = $clog2(CLR_DEPTH);
  localparam int SW       = QUO_W + TIW;

  // Configuration registers.
  logic [6:0]  topics_q;
  logic [23:0] alpha_q, beta_q;
  logic [20:0] vocab_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      topics_q <= RST_TOPICS;
      alpha_q  <= RST_ALPHA;
      beta_q   <= RST_BETA;
      vocab_q  <= RST_VOCAB;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TOPICS: topics_q <= cfg_wdata_i[6:0];
        REG_ALPHA:  alpha_q  <= cfg_wdata_i;
        REG_BETA:   beta_q   <= cfg_wdata_i;
        REG_VOCAB:  vocab_q  <= cfg_wdata_i[20:0];
        default: ;
      endcase
    end
  end

  // Last topic index in use: zero acts as one, large values clamp.
  logic [TIW-1:0] nt_last;
  always_comb begin
    if (topics_q == '0) nt_last = '0;
    else if (32'(topics_q) > MAX_TOPICS) nt_last = TIW'(MAX_TOPICS - 1);
    else nt_last = TIW'(topics_q - 7'd1);
  end

  // Item registers.
  logic [DOC_W-1:0]   d_q;
  logic [WORD_W-1:0]  w_q;
  logic               hp_q;
  logic [PRIOR_W-1:0] prior_q;
  logic [RAND_W-1:0]  r_q;
  logic [DTAW-1:0]    dbase_q;
  logic [WTAW-1:0]    wbase_q;
  logic [44:0]        bv_q;
  logic               uf_q;
  logic [TIW-1:0]     t_q;
  logic [CLW-1:0]     clr_q;

  logic [32:0] dlim, wlim;
  assign dlim = 33'(MAX_DOCS) << cmd_i.red_k;
  assign wlim = 33'(MAX_WORDS) << cmd_i.red_k;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      d_q     <= doc_index_i;
      w_q     <= word_index_i;
      hp_q    <= has_prior_topic_i;
      prior_q <= prior_topic_i;
      r_q     <= random_fraction_i;
    end
    if (cmd_i.red_en) begin
      if (33'(d_q) >= dlim) d_q <= d_q - DOC_W'(dlim);
      if (33'(w_q) >= wlim) w_q <= w_q - WORD_W'(wlim);
    end
    if (cmd_i.base_ld) begin
      dbase_q <= DTAW'(32'(d_q) * MAX_TOPICS);
      wbase_q <= WTAW'(32'(w_q) * MAX_TOPICS);
      bv_q    <= 45'(beta_q) * 45'(vocab_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q   <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i.t_clr) t_q <= '0;
      else if (cmd_i.t_inc) t_q <= t_q + 1'b1;
      if (cmd_i.mem_wr && cmd_i.asel == AS_CLEAR && !sts_o.clr_last) clr_q <= clr_q + 1'b1;
    end
  end

  assign sts_o.need_rm  = hp_q && (32'(prior_q) < MAX_TOPICS);
  assign sts_o.t_last   = (t_q == nt_last);
  assign sts_o.clr_last = (32'(clr_q) == CLR_DEPTH - 1);

  // Count memories.
  logic [15:0] dt_mem [DT_DEPTH];
  logic [23:0] wt_mem [WT_DEPTH];
  logic [31:0] tt_mem [MAX_TOPICS];
  logic [15:0] dt_rd_q;
  logic [23:0] wt_rd_q;
  logic [31:0] tt_rd_q;

  logic [TIW-1:0]  off;
  logic [DTAW-1:0] dt_addr;
  logic [WTAW-1:0] wt_addr;
  logic [TIW-1:0]  tt_addr;
  logic            clr_sel;
  logic [15:0]     dt_wd;
  logic [23:0]     wt_wd;
  logic [31:0]     tt_wd;
  logic            dt_we, wt_we, tt_we;

  assign clr_sel = (cmd_i.asel == AS_CLEAR);
  assign off     = (cmd_i.asel == AS_PRIOR) ? TIW'(prior_q) : t_q;
  assign dt_addr = clr_sel ? DTAW'(clr_q) : DTAW'(dbase_q + DTAW'(off));
  assign wt_addr = clr_sel ? WTAW'(clr_q) : WTAW'(wbase_q + WTAW'(off));
  assign tt_addr = clr_sel ? TIW'(clr_q) : off;
  assign dt_we   = cmd_i.mem_wr && (!clr_sel || 33'(clr_q) < 33'(DT_DEPTH));
  assign wt_we   = cmd_i.mem_wr && (!clr_sel || 33'(clr_q) < 33'(WT_DEPTH));
  assign tt_we   = cmd_i.mem_wr && (!clr_sel || 33'(clr_q) < 33'(MAX_TOPICS));

  always_comb begin
    unique case (cmd_i.wop)
      WOP_DEC: begin
        dt_wd = (dt_rd_q == '0) ? dt_rd_q : dt_rd_q - 16'd1;
        wt_wd = (wt_rd_q == '0) ? wt_rd_q : wt_rd_q - 24'd1;
        tt_wd = (tt_rd_q == '0) ? tt_rd_q : tt_rd_q - 32'd1;
      end
      WOP_INC: begin
        dt_wd = (dt_rd_q == '1) ? dt_rd_q : dt_rd_q + 16'd1;
        wt_wd = (wt_rd_q == '1) ? wt_rd_q : wt_rd_q + 24'd1;
        tt_wd = (tt_rd_q == '1) ? tt_rd_q : tt_rd_q + 32'd1;
      end
      default: begin
        dt_wd = '0;
        wt_wd = '0;
        tt_wd = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dt_we) dt_mem[dt_addr] <= dt_wd;
    if (wt_we) wt_mem[wt_addr] <= wt_wd;
    if (tt_we) tt_mem[tt_addr] <= tt_wd;
    if (cmd_i.mem_rd) begin
      dt_rd_q <= dt_mem[dt_addr];
      wt_rd_q <= wt_mem[wt_addr];
      tt_rd_q <= tt_mem[tt_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uf_q <= 1'b0;
    end else if (cmd_i.latch) begin
      uf_q <= 1'b0;
    end else if (cmd_i.mem_wr && cmd_i.wop == WOP_DEC) begin
      if (dt_rd_q == '0 || wt_rd_q == '0 || tt_rd_q == '0) uf_q <= 1'b1;
    end
  end

  // Weight arithmetic and serial divider.
  logic [32:0] a_sum, b_sum;
  logic [39:0] wt_sh;
  logic [48:0] den_sum;
  logic [31:0] a_q, b_q;
  logic [48:0] den_q;
  logic [63:0] p_q;
  logic [48:0] rem_q;
  logic [47:0] plo_q, quo_q;
  logic        sat_q;
  logic [49:0] trial;
  logic        ge;
  logic [47:0] wq;

  assign a_sum   = 33'(alpha_q) + {1'b0, dt_rd_q, 16'd0};
  assign wt_sh   = {wt_rd_q, 16'd0};
  assign b_sum   = (wt_sh[39:32] != '0) ? '1 : 33'(beta_q) + {1'b0, wt_sh[31:0]};
  assign den_sum = 49'(bv_q) + 49'({tt_rd_q, 16'd0});
  assign trial   = {rem_q, plo_q[47]};
  assign ge      = trial >= {1'b0, den_q};
  assign wq      = sat_q ? '1 : quo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ab_ld) begin
      a_q   <= a_sum[32] ? '1 : a_sum[31:0];
      b_q   <= b_sum[32] ? '1 : b_sum[31:0];
      den_q <= (den_sum == '0) ? 49'd1 : den_sum;
    end
    if (cmd_i.mul_ld) p_q <= 64'(a_q) * 64'(b_q);
    if (cmd_i.div_init) begin
      sat_q <= 49'(p_q[63:48]) >= den_q;
      rem_q <= 49'(p_q[63:48]);
      plo_q <= p_q[47:0];
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? 49'(trial - {1'b0, den_q}) : trial[48:0];
      quo_q <= {quo_q[46:0], ge};
      plo_q <= {plo_q[46:0], 1'b0};
    end
  end

  // Weight buffer, sum, threshold and cumulative search.
  logic [47:0]    wb_mem [MAX_TOPICS];
  logic [47:0]    wb_rd_q;
  logic [SW-1:0]  sum_q, run_q, hi_q, thr_q, run_d;
  logic [63:0]    lo_q;

  assign run_d     = run_q + SW'(wb_rd_q);
  assign sts_o.hit = run_d > thr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) wb_mem[t_q] <= wq;
    if (cmd_i.wb_rd) wb_rd_q <= wb_mem[t_q];
    if (cmd_i.base_ld) sum_q <= '0;
    else if (cmd_i.acc) sum_q <= sum_q + SW'(wq);
    if (cmd_i.thr_hi) hi_q <= SW'(sum_q[SW-1:32] * r_q);
    if (cmd_i.thr_lo) lo_q <= 64'(sum_q[31:0]) * 64'(r_q);
    if (cmd_i.thr_sum) begin
      thr_q <= hi_q + SW'(lo_q[63:32]);
      run_q <= '0;
    end else if (cmd_i.srch) begin
      run_q <= run_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      chosen_topic_o    <= TOPIC_W'(t_q);
      topic_changed_o   <= !hp_q || (32'(t_q) != 32'(prior_q));
      count_underflow_o <= uf_q;
    end
  end

endmodule
`default_nettype wire

[hdl/lda_gibbs_token_resample.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LDA collapsed Gibbs token resampler
// Removes a token's old topic, weighs every topic in use, draws a new one by
// inverse CDF and adds the token back under it.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat contents
//  tok_i    in   doc_index, word_index, has_prior_topic, prior_topic, random_fraction
//  res_o    out  chosen_topic, topic_changed, count_underflow
//  cfg_*    in   write enable, register index, write data
//
// Each token runs through removal of its old topic, when it has one, a weight
// pass over the T topics in use and a draw that scans S of them, where T is the
// number of topics in use and S is the number of topics the draw scans (1..T).
// The 48-step serial divider, one quotient bit a cycle per topic, dominates.
// After reset the count memories are swept to zero, one entry a cycle, over
// max(MAX_DOCS, MAX_WORDS) * MAX_TOPICS entries; no token is taken meanwhile.
// A finished result waits in the output register while the next token is taken.
// ----------------------------------------------------------------------------
module lda_gibbs_token_resample
  import lgtr_pkg::*;
#(
  parameter int MAX_TOPICS = DEF_MAX_TOPICS,
  parameter int MAX_DOCS   = DEF_MAX_DOCS,
  parameter int MAX_WORDS  = DEF_MAX_WORDS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  lgtr_tok_if.sink                   tok_i,
  lgtr_res_if.source                 res_o
);

  cmd_t cmd;
  sts_t sts;

  // The controller owns sequencing and the result valid flag.
  lgtr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tok_i.valid),
    .in_ready_o  (tok_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the counts, the arithmetic and the result payload.
  lgtr_dp #(
    .MAX_TOPICS (MAX_TOPICS),
    .MAX_DOCS   (MAX_DOCS),
    .MAX_WORDS  (MAX_WORDS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .doc_index_i       (tok_i.doc_index),
    .word_index_i      (tok_i.word_index),
    .has_prior_topic_i (tok_i.has_prior_topic),
    .prior_topic_i     (tok_i.prior_topic),
    .random_fraction_i (tok_i.random_fraction),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .chosen_topic_o    (res_o.chosen_topic),
    .topic_changed_o   (res_o.topic_changed),
    .count_underflow_o (res_o.count_underflow)
  );

  // A token in work blocks the next one.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_i.valid && tok_i.ready |=> !tok_i.ready)
    else $error("token accepted while another is in work");

  // A result only appears when a token has just finished, never from idle.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(!tok_i.ready))
    else $error("result raised while idle");

  // Commands to the count memories never read and write in one cycle.
  a_mem_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.mem_rd && cmd.mem_wr))
    else $error("count memory read and write in the same cycle");

endmodule
`default_nettype wire

[tb/lda_gibbs_token_resample_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LDA token resampler testbench
// Drives tokens through the resampler in bursts while the result side stalls,
// predicts every drawn topic from a copy of the count tables, and compares
// each result beat with the oldest prediction. Several prior settings are
// visited, including both ends of topics, alpha and beta and the top of vocab.
// ----------------------------------------------------------------------------
module lda_gibbs_token_resample_tb;
  import lgtr_pkg::*;

  localparam int NT_MAX    = DEF_MAX_TOPICS;
  localparam int N_DOCS    = DEF_MAX_DOCS;
  localparam int N_WORDS   = DEF_MAX_WORDS;
  localparam int CYCLE_CAP = 5000000;
  localparam int SLOTS     = 48;
  localparam int N_ROWS    = 12;
  localparam int N_PHASES  = 7;

  typedef struct packed {
    logic [5:0] topic;
    logic       changed;
    logic       underflow;
  } draw_t;

  // One row of the directed table; known rows carry a hand-worked result.
  typedef struct packed {
    logic [9:0]  doc;
    logic [11:0] word;
    logic        has_prior;
    logic [5:0]  prior;
    logic [31:0] frac;
    logic        known;
    draw_t       res;
  } row_t;

  // Register settings for one phase of the run and how many tokens it sends.
  typedef struct packed {
    logic [23:0] topics;
    logic [23:0] alpha;
    logic [23:0] beta;
    logic [23:0] vocab;
    logic [31:0] items;
  } phase_t;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lgtr_tok_if tok();
  lgtr_res_if res();

  lda_gibbs_token_resample DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .tok_i      (tok),
    .res_o      (res)
  );

  // Private copy of the count tables and the prior registers.
  logic [15:0] doc_cnt  [N_DOCS*NT_MAX];
  logic [23:0] word_cnt [N_WORDS*NT_MAX];
  logic [31:0] topic_tot[NT_MAX];
  logic [47:0] weights  [NT_MAX];
  logic [6:0]  m_topics;
  logic [23:0] m_alpha;
  logic [23:0] m_beta;
  logic [20:0] m_vocab;

  draw_t pending_draws[$];
  int    mismatches;
  int    results_seen;
  int    cycles;
  bit    stim_done;

  // A small corpus of tokens whose topics are followed, so that most beats
  // carry the prior topic the block itself assigned last time.
  logic [9:0]  c_doc   [SLOTS];
  logic [11:0] c_word  [SLOTS];
  logic        c_placed[SLOTS];
  logic [5:0]  c_topic [SLOTS];

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("Timeout after %0d cycles", cycles);
      $display("** lda_gibbs_token_resample: FAILED **");
      $finish;
    end
  end

  // Predict one token: remove the old topic, weigh every topic in use, draw by inverse
  // CDF and add the token back under the drawn topic.
  function automatic draw_t resample_token(input logic [9:0] doc, input logic [11:0] word,
                                           input logic has_prior, input logic [5:0] prior,
                                           input logic [31:0] frac);
    int unsigned nt;
    int          db;
    int          wb;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] den;
    logic [63:0] q;
    logic [63:0] sum;
    logic [63:0] thr;
    logic [63:0] run;
    int          pick;
    draw_t       r;
    nt  = (m_topics == 0) ? 1 : ((m_topics > NT_MAX) ? NT_MAX : m_topics);
    db  = int'(doc) * NT_MAX;
    wb  = int'(word) * NT_MAX;
    r   = '0;
    sum = '0;
    run = '0;
    if (has_prior) begin
      if (doc_cnt[db+prior] == 0) r.underflow = 1'b1;
      else doc_cnt[db+prior] = doc_cnt[db+prior] - 16'd1;
      if (word_cnt[wb+prior] == 0) r.underflow = 1'b1;
      else word_cnt[wb+prior] = word_cnt[wb+prior] - 24'd1;
      if (topic_tot[prior] == 0) r.underflow = 1'b1;
      else topic_tot[prior] = topic_tot[prior] - 32'd1;
    end
    for (int t = 0; t < nt; t++) begin
      a = 64'(m_alpha) + (64'(doc_cnt[db+t]) << 16);
      if (a > 64'hFFFF_FFFF) a = 64'hFFFF_FFFF;
      b = 64'(m_beta) + (64'(word_cnt[wb+t]) << 16);
      if (b > 64'hFFFF_FFFF) b = 64'hFFFF_FFFF;
      den = 64'(m_beta) * 64'(m_vocab) + (64'(topic_tot[t]) << 16);
      if (den == 0) den = 1;   // a zero denominator counts as one
      q = (a * b) / den;
      if (q > 64'hFFFF_FFFF_FFFF) q = 64'hFFFF_FFFF_FFFF;
      weights[t] = q[47:0];
      sum = sum + q;
    end
    thr  = (sum >> 32) * 64'(frac) + (((sum & 64'hFFFF_FFFF) * 64'(frac)) >> 32);
    pick = nt - 1;             // nothing above the threshold: last topic
    for (int t = 0; t < nt; t++) begin
      run = run + 64'(weights[t]);
      if (run > thr) begin
        pick = t;
        break;
      end
    end
    if (doc_cnt[db+pick] != 16'hFFFF) doc_cnt[db+pick] = doc_cnt[db+pick] + 16'd1;
    if (word_cnt[wb+pick] != 24'hFF_FFFF) word_cnt[wb+pick] = word_cnt[wb+pick] + 24'd1;
    if (topic_tot[pick] != 32'hFFFF_FFFF) topic_tot[pick] = topic_tot[pick] + 32'd1;
    r.topic   = pick[5:0];
    r.changed = !has_prior || (pick[5:0] != prior);
    return r;
  endfunction

  task automatic write_prior_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    case (idx)
      REG_TOPICS: m_topics = val[6:0];
      REG_ALPHA:  m_alpha  = val;
      REG_BETA:   m_beta   = val;
      REG_VOCAB:  m_vocab  = val[20:0];
      default: ;
    endcase
  endtask

  // Offer one token and hold it until a beat takes it; the prediction is made
  // at that very edge so that the corpus follows the block's own draws.
  task automatic send_token(input logic [9:0] doc, input logic [11:0] word,
                            input logic hp, input logic [5:0] prior, input logic [31:0] frac,
                            input bit known, input draw_t typed, input int slot);
    draw_t d;
    tok.valid           = 1'b1;
    tok.doc_index       = doc;
    tok.word_index      = word;
    tok.has_prior_topic = hp;
    tok.prior_topic     = prior;
    tok.random_fraction = frac;
    do @(posedge clk_i); while (!(tok.valid && tok.ready));
    d = resample_token(doc, word, hp, prior, frac);
    pending_draws.push_back(known ? typed : d);
    if (slot >= 0) begin
      c_placed[slot] = 1'b1;
      c_topic[slot]  = d.topic;
    end
    @(negedge clk_i);
  endtask

  // Wait until every predicted result has come back, then let the block settle.
  task automatic drain_results();
    tok.valid = 1'b0;
    while (pending_draws.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  row_t   rows  [N_ROWS];
  phase_t phases[N_PHASES];

  // Token side: directed table first, then random phases in bursts.
  initial begin
    int          burst_left;
    int          slot;
    int          kind;
    logic [9:0]  doc_pool [6];
    logic [11:0] word_pool[8];
    logic [5:0]  pr;
    cycles       = 0;
    mismatches   = 0;
    results_seen = 0;
    stim_done    = 1'b0;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_TOPICS;
    cfg_wdata    = '0;
    tok.valid           = 1'b0;
    tok.doc_index       = '0;
    tok.word_index      = '0;
    tok.has_prior_topic = 1'b0;
    tok.prior_topic     = '0;
    tok.random_fraction = '0;
    m_topics = RST_TOPICS;
    m_alpha  = RST_ALPHA;
    m_beta   = RST_BETA;
    m_vocab  = RST_VOCAB;
    foreach (doc_cnt[i]) doc_cnt[i] = '0;
    foreach (word_cnt[i]) word_cnt[i] = '0;
    foreach (topic_tot[i]) topic_tot[i] = '0;

    // With empty tables and the reset priors every weight rounds to zero, so
    // the first draws land on the last topic in use.
    rows[0]  = '{10'd0, 12'd0, 1'b0, 6'd0, 32'h0, 1'b1, '{6'd49, 1'b1, 1'b0}};
    rows[1]  = '{10'd1023, 12'd4095, 1'b1, 6'd63, 32'hFFFF_FFFF, 1'b1,
                 '{6'd49, 1'b1, 1'b1}};
    rows[2]  = '{10'd0, 12'd0, 1'b1, 6'd49, 32'hFFFF_FFFF, 1'b0, '0};
    rows[3]  = '{10'd0, 12'd0, 1'b1, 6'd49, 32'h0, 1'b0, '0};
    rows[4]  = '{10'd512, 12'd2048, 1'b0, 6'd0, 32'h8000_0000, 1'b0, '0};
    rows[5]  = '{10'd0, 12'd4095, 1'b1, 6'd0, 32'h1, 1'b0, '0};
    rows[6]  = '{10'd1023, 12'd0, 1'b1, 6'd63, 32'h7FFF_FFFF, 1'b0, '0};
    rows[7]  = '{10'd341, 12'd2730, 1'b1, 6'd21, 32'h5555_5555, 1'b0, '0};
    rows[8]  = '{10'd682, 12'd1365, 1'b1, 6'd42, 32'hAAAA_AAAA, 1'b0, '0};
    rows[9]  = '{10'd0, 12'd0, 1'b0, 6'd0, 32'hFFFF_FFFF, 1'b0, '0};
    rows[10] = '{10'd1023, 12'd4095, 1'b1, 6'd49, 32'h0, 1'b0, '0};
    rows[11] = '{10'd0, 12'd0, 1'b1, 6'd49, 32'hC000_0000, 1'b0, '0};

    // Mostly few topics to keep the run short; the widest setting gets only a
    // handful of tokens. Out-of-range topic counts and masked writes included.
    phases[0] = '{24'd4, 24'h01_0000, 24'h00_8000, 24'd16, 32'd600};
    phases[1] = '{24'd0, 24'h0, 24'h0, 24'd1, 32'd100};
    phases[2] = '{24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 32'd16};
    phases[3] = '{24'd8, 24'h00_4000, 24'h02_0000, 24'd3, 32'd450};
    phases[4] = '{24'd64, 24'h00_0001, 24'h00_0001, 24'd1048576, 32'd12};
    phases[5] = '{24'd2, 24'h10_0000, 24'h00_1000, 24'd200, 32'd500};
    phases[6] = '{24'd1, 24'h00_0100, 24'h00_0100, 24'd1, 32'd250};

    for (int i = 0; i < SLOTS; i++) begin
      c_placed[i] = 1'b0;
      c_topic[i]  = '0;
    end

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // The first beat is held off by the clearing sweep after reset.
    foreach (rows[i])
      send_token(rows[i].doc, rows[i].word, rows[i].has_prior, rows[i].prior,
                 rows[i].frac, rows[i].known, rows[i].res, -1);
    drain_results();

    burst_left = 0;
    foreach (phases[p]) begin
      write_prior_reg(REG_TOPICS, phases[p].topics);
      write_prior_reg(REG_ALPHA,  phases[p].alpha);
      write_prior_reg(REG_BETA,   phases[p].beta);
      write_prior_reg(REG_VOCAB,  phases[p].vocab);
      // Fresh corpus per phase, clustered on a few documents and words so the
      // counts build up and the weights differ between topics.
      foreach (doc_pool[i]) doc_pool[i] = 10'($urandom());
      foreach (word_pool[i]) word_pool[i] = 12'($urandom());
      for (int i = 0; i < SLOTS; i++) begin
        c_doc[i]    = doc_pool[$urandom_range(0, 5)];
        c_word[i]   = word_pool[$urandom_range(0, 7)];
        c_placed[i] = 1'b0;
      end
      for (int n = 0; n < phases[p].items; n++) begin
        if (burst_left == 0) begin
          tok.valid  = 1'b0;
          if ($urandom_range(0, 9) > 2) repeat ($urandom_range(1, 20)) @(negedge clk_i);
          burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
          slot = $urandom_range(0, SLOTS - 1);
          send_token(c_doc[slot], c_word[slot], c_placed[slot], c_topic[slot],
                     $urandom(), 1'b0, '0, slot);
        end else if (kind < 88) begin
          // A corpus token that claims the wrong prior topic.
          slot = $urandom_range(0, SLOTS - 1);
          pr   = 6'($urandom());
          send_token(c_doc[slot], c_word[slot], 1'b1, pr, $urandom(), 1'b0, '0, -1);
        end else begin
          send_token(10'($urandom()), 12'($urandom()), 1'($urandom()), 6'($urandom()),
                     $urandom(), 1'b0, '0, -1);
        end
      end
      drain_results();
    end

    stim_done = 1'b1;
    repeat (100) @(negedge clk_i);
    if (mismatches == 0 && pending_draws.size() == 0) begin
      $display("** lda_gibbs_token_resample: PASSED **");
    end else begin
      $display("** lda_gibbs_token_resample: FAILED **");
    end
    $finish;
  end

  // Result side: the stall pattern changes at random, and once it holds off
  // for a long stretch so that the block backs up into its input.
  initial begin
    int  mode;
    int  left;
    int  tick;
    bit  held;
    res.ready = 1'b0;
    mode = 0;
    left = 0;
    tick = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (!held && results_seen >= 300) begin
        held      = 1'b1;
        res.ready = 1'b0;
        repeat (4000) @(negedge clk_i);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(50, 400);
      end
      left--;
      case (mode)
        0: res.ready = 1'b1;
        1: res.ready = 1'($urandom_range(0, 1));
        2: res.ready = (tick % 4) == 0;
        default: res.ready = $urandom_range(0, 9) == 0;
      endcase
    end
  end

  // Every result beat is compared with the oldest prediction.
  always @(posedge clk_i) begin
    draw_t want;
    draw_t got;
    if (rst_ni && res.valid && res.ready) begin
      got = '{res.chosen_topic, res.topic_changed, res.count_underflow};
      results_seen <= results_seen + 1;
      if (pending_draws.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("Unexpected result beat: topic %0d changed %0b underflow %0b",
                   got.topic, got.changed, got.underflow);
      end else begin
        want = pending_draws.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("Result %0d: expected topic %0d changed %0b underflow %0b, got %0d %0b %0b",
                     results_seen, want.topic, want.changed, want.underflow,
                     got.topic, got.changed, got.underflow);
        end
      end
    end
  end

endmodule
